/* rtl/fspcp_pkg.sv */
// ---------------------------------------------------------------------------
// fspcp_pkg: shared types and constants for the serial command parser
// Beat structs, protocol characters and the decimal weight table.
// ---------------------------------------------------------------------------
`default_nettype none

package fspcp_pkg;

    localparam int VAL_W      = 20;
    localparam int NUM_DIGITS = 6;

    localparam logic [7:0] CH_START = 8'h2B;  // '+'
    localparam logic [7:0] CH_END   = 8'h23;  // '#'
    localparam logic [7:0] CH_GET   = 8'h67;  // 'g'
    localparam logic [7:0] CH_SET   = 8'h73;  // 's'
    localparam logic [7:0] CH_REPLY = 8'h70;  // 'p'
    localparam logic [7:0] CH_A     = 8'h61;  // 'a'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    localparam logic [VAL_W-1:0] MOD_LIMIT = 20'd1000000;

    typedef struct packed {
        logic             byte_valid;
        logic [7:0]       rx_byte;
        logic [VAL_W-1:0] live_rate;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } t_out_beat;

    // frame parser -> command executor
    typedef struct packed {
        logic             start;
        logic             len_get;   // frame held exactly two bytes
        logic             len_set;   // frame held exactly eight bytes
        logic [VAL_W-1:0] rate;
    } t_exec_req;

    // command executor -> reply formatter
    typedef struct packed {
        logic             start;
        logic [7:0]       id;
        logic [VAL_W-1:0] value;
    } t_reply;

    function automatic logic [VAL_W-1:0] dec_weight(input logic [2:0] pos);
        logic [VAL_W-1:0] w;
        case (pos)
            3'd0:    w = 20'd100000;
            3'd1:    w = 20'd10000;
            3'd2:    w = 20'd1000;
            3'd3:    w = 20'd100;
            3'd4:    w = 20'd10;
            default: w = 20'd1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/fspcp_store.sv */
// ---------------------------------------------------------------------------
// fspcp_store: frame byte memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fspcp_store #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/fspcp_exec.sv */
// ---------------------------------------------------------------------------
// fspcp_exec: command executor
// Walks the stored frame, parses id and value, reads or updates the
// parameter table and hands a reply request to the formatter.
// ---------------------------------------------------------------------------
`default_nettype none

module fspcp_exec #(
    parameter int FRAME_DEPTH = 16,
    parameter int NUM_PARAMS  = 16,
    parameter int AW          = $clog2(FRAME_DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire fspcp_pkg::t_exec_req i_req,
    output logic                      o_busy,
    output logic                      o_rd_en,
    output logic [AW-1:0]             o_rd_addr,
    input  wire logic [7:0]           i_rd_data,
    output fspcp_pkg::t_reply         o_reply
);

    localparam int IDX_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam logic [7:0] ID_RT = 8'(fspcp_pkg::CH_A + NUM_PARAMS);

    // step s reads frame byte s (s < 8); its data shows up at step s+1
    localparam logic [3:0] STEP_CMD   = 4'd1;
    localparam logic [3:0] STEP_ID    = 4'd2;
    localparam logic [3:0] STEP_D0    = 4'd3;
    localparam logic [3:0] STEP_D5    = 4'd8;
    localparam logic [3:0] STEP_TAB   = 4'd9;
    localparam logic [3:0] STEP_DONE  = 4'd10;
    localparam logic [3:0] STEP_NRD   = 4'd8;

    logic                         r_busy;
    logic [3:0]                   r_step;
    logic                         r_len_get;
    logic                         r_len_set;
    logic [fspcp_pkg::VAL_W-1:0]  r_rate;
    logic [7:0]                   r_cmd;
    logic [7:0]                   r_id;
    logic [fspcp_pkg::VAL_W-1:0]  r_val;
    logic [fspcp_pkg::VAL_W-1:0]  r_tab [NUM_PARAMS];
    logic [fspcp_pkg::VAL_W-1:0]  r_tab_q;
    logic                         r_tab_hit;
    logic [NUM_PARAMS-1:0]        r_tvalid;
    fspcp_pkg::t_reply            r_reply;

    logic [IDX_W-1:0]             idx;
    logic [3:0]                   digit;
    logic                         is_tab;
    logic                         is_rt;
    logic                         do_get;
    logic                         do_set;
    logic                         fin;
    logic                         tab_we;

    assign idx    = IDX_W'(r_id - fspcp_pkg::CH_A);
    assign digit  = (i_rd_data >= fspcp_pkg::CH_ZERO && i_rd_data <= fspcp_pkg::CH_NINE)
                  ? 4'(i_rd_data - fspcp_pkg::CH_ZERO) : 4'd0;
    assign is_tab = (r_id >= fspcp_pkg::CH_A) && (r_id < ID_RT);
    assign is_rt  = (r_id == ID_RT);
    assign do_get = (r_cmd == fspcp_pkg::CH_GET) && r_len_get && (is_tab || is_rt);
    assign do_set = (r_cmd == fspcp_pkg::CH_SET) && r_len_set && is_tab;
    assign fin    = r_busy && (r_step == STEP_DONE);
    assign tab_we = fin && do_set;

    // still busy in the hand-off cycle, before the formatter shows busy
    assign o_busy    = r_busy || r_reply.start;
    assign o_rd_en   = r_busy && (r_step < STEP_NRD);
    assign o_rd_addr = AW'(r_step[2:0]);
    assign o_reply   = r_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_step        <= '0;
            r_reply.start <= 1'b0;
            r_tvalid      <= '0;
        end else begin
            r_reply.start <= fin && (do_get || do_set);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (fin) begin
                    r_busy <= 1'b0;
                end
            end
            if (tab_we) begin
                r_tvalid[idx] <= 1'b1;
            end
            if (fin) begin
                r_reply.id <= (do_get && is_rt) ? fspcp_pkg::CH_A : r_id;
                if (do_set) begin
                    r_reply.value <= r_val;
                end else if (is_rt) begin
                    r_reply.value <= r_rate;
                end else begin
                    r_reply.value <= r_tab_hit ? r_tab_q : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_len_get <= i_req.len_get;
            r_len_set <= i_req.len_set;
            r_rate    <= i_req.rate;
            r_val     <= '0;
        end else if (r_busy) begin
            if (r_step == STEP_CMD) begin
                r_cmd <= i_rd_data;
            end
            if (r_step == STEP_ID) begin
                r_id <= i_rd_data;
            end
            if (r_step >= STEP_D0 && r_step <= STEP_D5) begin
                r_val <= (r_val << 3) + (r_val << 1) + fspcp_pkg::VAL_W'(digit);
            end
        end
    end

    // parameter table; entries never written read as zero via r_tvalid
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[idx] <= r_val;
        end
        if (r_busy && r_step == STEP_TAB) begin
            r_tab_q   <= r_tab[idx];
            r_tab_hit <= r_tvalid[idx];
        end
    end

endmodule

`default_nettype wire

/* rtl/fspcp_fmt.sv */
// ---------------------------------------------------------------------------
// fspcp_fmt: reply formatter
// Converts the value to six decimal digits by restoring subtraction, one
// compare-subtract per cycle, then streams the ten-byte reply.
// ---------------------------------------------------------------------------
`default_nettype none

module fspcp_fmt (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fspcp_pkg::t_reply i_reply,
    output logic                   o_busy,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output fspcp_pkg::t_out_beat   o_data
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_SEND
    } t_fstate;

    localparam logic [3:0] BEAT_START = 4'd0;
    localparam logic [3:0] BEAT_TAG   = 4'd1;
    localparam logic [3:0] BEAT_ID    = 4'd2;
    localparam logic [3:0] BEAT_D0    = 4'd3;
    localparam logic [3:0] BEAT_END   = 4'd9;
    localparam logic [2:0] POS_LAST   = 3'd5;

    t_fstate                      r_state;
    logic [fspcp_pkg::VAL_W-1:0]  r_rem;
    logic [7:0]                   r_id;
    logic [2:0]                   r_pos;
    logic [1:0]                   r_bit;
    logic [3:0]                   r_dig [fspcp_pkg::NUM_DIGITS];
    logic [3:0]                   r_idx;
    logic                         r_ovalid;
    fspcp_pkg::t_out_beat         r_odata;

    logic [fspcp_pkg::VAL_W-1:0]  w;
    logic                         ge;
    logic                         can_load;
    logic [2:0]                   dsel;
    logic [7:0]                   beat_byte;
    logic [fspcp_pkg::VAL_W-1:0]  val_mod;

    assign w        = fspcp_pkg::dec_weight(r_pos) << r_bit;
    assign ge       = (r_rem >= w);
    assign can_load = !r_ovalid || i_ready;
    assign dsel     = 3'(r_idx - BEAT_D0);
    assign val_mod  = (i_reply.value >= fspcp_pkg::MOD_LIMIT)
                    ? i_reply.value - fspcp_pkg::MOD_LIMIT : i_reply.value;

    always_comb begin
        case (r_idx)
            BEAT_START: beat_byte = fspcp_pkg::CH_START;
            BEAT_TAG:   beat_byte = fspcp_pkg::CH_REPLY;
            BEAT_ID:    beat_byte = r_id;
            BEAT_END:   beat_byte = fspcp_pkg::CH_END;
            default:    beat_byte = fspcp_pkg::CH_ZERO + 8'(r_dig[dsel]);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_reply.start) begin
                        r_rem   <= val_mod;
                        r_id    <= i_reply.id;
                        r_pos   <= '0;
                        r_bit   <= 2'd3;
                        r_state <= F_CONV;
                    end
                end
                F_CONV: begin
                    r_dig[r_pos][r_bit] <= ge;
                    if (ge) begin
                        r_rem <= r_rem - w;
                    end
                    r_bit <= r_bit - 2'd1;
                    if (r_bit == 2'd0) begin
                        r_pos <= r_pos + 3'd1;
                        if (r_pos == POS_LAST) begin
                            r_idx   <= BEAT_START;
                            r_state <= F_SEND;
                        end
                    end
                end
                F_SEND: begin
                    if (can_load) begin
                        r_idx <= r_idx + 4'd1;
                        if (r_idx == BEAT_END) begin
                            r_state <= F_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
            if (r_state == F_SEND && can_load) begin
                r_ovalid        <= 1'b1;
                r_odata.tx_byte <= beat_byte;
                r_odata.last    <= (r_idx == BEAT_END);
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_busy  = (r_state != F_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

`default_nettype wire

/* rtl/framed_serial_param_command_parser.sv */
// ---------------------------------------------------------------------------
// framed_serial_param_command_parser: framed get/set parameter commands
// Collects '+'...'#' frames into a byte memory, runs 'g'/'s' commands
// against a parameter table and streams ten-byte replies.
//
//   Channel | Dir | Handshake             | Beat
//   --------+-----+-----------------------+-----------------------------------
//   in      | in  | i_in_valid/o_in_ready | one poll: byte_valid, rx_byte, rate
//   out     | out | o_out_valid/i_out_ready| one reply byte, last on '#'
//
// Polls are taken one per cycle while o_in_ready is high. A closing '#' of
// a non-empty frame starts the executor, which walks the frame memory and
// the table port; after the hand-off the formatter converts the value to
// digits (one compare-subtract per cycle), loads the output register and
// sends ten reply beats. Such a '#' is held off while the executor or the
// reply path is still busy; all other polls pass. Reset is synchronous;
// table valid bits clear at once, so no clearing pass follows reset.
// ---------------------------------------------------------------------------
`default_nettype none

module framed_serial_param_command_parser #(
    parameter int FRAME_DEPTH = 16,
    parameter int NUM_PARAMS  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire fspcp_pkg::t_in_beat  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output fspcp_pkg::t_out_beat      o_out_data
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int FW = $clog2(FRAME_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_RESET,
        MODE_WAIT_START,
        MODE_WAIT_END
    } t_mode;

    t_mode                 r_mode;
    logic [FW-1:0]         r_fill;

    logic                  in_fire;
    logic                  is_end;
    logic                  trig;
    logic                  st_wr;
    logic                  exec_busy;
    logic                  fmt_busy;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [7:0]            rd_data;
    fspcp_pkg::t_exec_req  exec_req;
    fspcp_pkg::t_reply     reply;

    assign is_end  = i_in_data.byte_valid && (i_in_data.rx_byte == fspcp_pkg::CH_END);
    assign trig    = (r_mode == MODE_WAIT_END) && is_end && (r_fill != '0);
    assign o_in_ready = !(i_in_valid && trig && (exec_busy || fmt_busy));
    assign in_fire = i_in_valid && o_in_ready;
    assign st_wr   = in_fire && (r_mode == MODE_WAIT_END) && i_in_data.byte_valid
                  && !is_end && (r_fill < FW'(FRAME_DEPTH));

    assign exec_req.start   = in_fire && trig;
    assign exec_req.len_get = (r_fill == FW'(2));
    assign exec_req.len_set = (r_fill == FW'(8));
    assign exec_req.rate    = i_in_data.live_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
            r_fill <= '0;
        end else if (in_fire) begin
            case (r_mode)
                MODE_RESET: begin
                    r_fill <= '0;
                    r_mode <= MODE_WAIT_START;
                end
                MODE_WAIT_START: begin
                    if (i_in_data.byte_valid && i_in_data.rx_byte == fspcp_pkg::CH_START) begin
                        r_mode <= MODE_WAIT_END;
                    end
                end
                MODE_WAIT_END: begin
                    if (i_in_data.byte_valid) begin
                        if (is_end) begin
                            r_mode <= MODE_RESET;
                        end else if (st_wr) begin
                            r_fill <= r_fill + FW'(1);
                        end else begin
                            // store full: drop the frame
                            r_mode <= MODE_RESET;
                        end
                    end
                end
                default: begin
                    r_mode <= MODE_RESET;
                end
            endcase
        end
    end

    fspcp_store #(
        .DEPTH (FRAME_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr),
        .i_wr_addr (AW'(r_fill)),
        .i_wr_data (i_in_data.rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fspcp_exec #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .NUM_PARAMS  (NUM_PARAMS),
        .AW          (AW)
    ) u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (exec_req),
        .o_busy    (exec_busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_reply   (reply)
    );

    fspcp_fmt u_fmt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_reply (reply),
        .o_busy  (fmt_busy),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(FRAME_DEPTH))
        else $error("fill count past frame depth");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_req.start |-> (!exec_busy && !fmt_busy))
        else $error("command started while executor or reply path busy");

    a_wait_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_WAIT_START) |-> (r_fill == '0))
        else $error("fill count not cleared before frame start");

    a_reply_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        reply.start |-> !fmt_busy)
        else $error("reply handed over while formatter busy");
`endif

endmodule

`default_nettype wire

/* tb/sv/framed_serial_param_command_parser_tb.sv */
// ---------------------------------------------------------------------------
// framed_serial_param_command_parser_tb: self-checking bench for the parser
// Feeds polls of framed get/set commands, broken frames and line noise, with
// random gaps and output stalls, and checks every reply beat against a
// cycle-free model of the frame parser and the parameter table.
// ---------------------------------------------------------------------------
module framed_serial_param_command_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         FRAME_DEPTH  = 16;
    localparam int         NUM_PARAMS   = 16;
    localparam logic [7:0] RUNTIME_ID   = fspcp_pkg::CH_A + 8'(NUM_PARAMS);
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 100;
    localparam int         TARGET_POLLS = 270;

    typedef enum logic [1:0] {PM_RESET, PM_IDLE, PM_BODY} t_parse_mode;
    typedef enum int {
        FK_GET, FK_SET, FK_GET_BAD_ID, FK_SET_BAD_ID, FK_BAD_LEN,
        FK_UNKNOWN, FK_EMPTY, FK_OVERFLOW, FK_NOISE
    } t_frame_kind;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    fspcp_pkg::t_in_beat  in_beat   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    fspcp_pkg::t_out_beat out_beat;

    // parser model state
    t_parse_mode pmode = PM_RESET;
    logic [7:0]  cmd_buf   [FRAME_DEPTH] = '{default: '0};
    int          cmd_len   = 0;
    logic [19:0] param_mem [NUM_PARAMS]  = '{default: '0};
    fspcp_pkg::t_out_beat reply_q[$];

    logic [7:0] frame_body[$];
    bit         quiet       = 1'b0;
    int         stall_left  = 0;
    int         idle_cycles = 0;
    int         n_polls     = 0;
    int         n_frames    = 0;
    int         n_beats     = 0;
    int         n_errors    = 0;

    always #1 clk = ~clk;

    framed_serial_param_command_parser #(
        .FRAME_DEPTH(FRAME_DEPTH),
        .NUM_PARAMS (NUM_PARAMS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_beat)
    );

    // ---------------- model ----------------

    function automatic void push_reply(input logic [7:0] id, input logic [19:0] value);
        int unsigned v;
        logic [7:0]  frame [10];
        v = value % 1000000;
        frame[0] = fspcp_pkg::CH_START;
        frame[1] = fspcp_pkg::CH_REPLY;
        frame[2] = id;
        for (int i = 8; i >= 3; i--) begin
            frame[i] = fspcp_pkg::CH_ZERO + 8'(v % 10);
            v = v / 10;
        end
        frame[9] = fspcp_pkg::CH_END;
        for (int i = 0; i < 10; i++) begin
            reply_q.push_back('{tx_byte: frame[i], last: (i == 9)});
        end
    endfunction

    function automatic void run_command(input logic [19:0] rate);
        logic [7:0]  id;
        logic [7:0]  c;
        int unsigned value;
        id = cmd_buf[1];
        value = 0;
        if (cmd_len == 0) begin
            return;
        end
        if (cmd_buf[0] == fspcp_pkg::CH_GET && cmd_len == 2) begin
            if (id >= fspcp_pkg::CH_A && id < RUNTIME_ID) begin
                push_reply(id, param_mem[id - fspcp_pkg::CH_A]);
            end else if (id == RUNTIME_ID) begin
                // runtime entry answers with index zero, not the id asked for
                push_reply(fspcp_pkg::CH_A, rate);
            end
        end else if (cmd_buf[0] == fspcp_pkg::CH_SET && cmd_len == 8
                     && id >= fspcp_pkg::CH_A && id < RUNTIME_ID) begin
            for (int i = 2; i < 8; i++) begin
                c = cmd_buf[i];
                value = value * 10
                      + ((c >= fspcp_pkg::CH_ZERO && c <= fspcp_pkg::CH_NINE)
                         ? (c - fspcp_pkg::CH_ZERO) : 0);
            end
            param_mem[id - fspcp_pkg::CH_A] = 20'(value);
            push_reply(id, param_mem[id - fspcp_pkg::CH_A]);
        end
    endfunction

    function automatic void model_poll(input fspcp_pkg::t_in_beat b);
        case (pmode)
            PM_IDLE: begin
                if (b.byte_valid && b.rx_byte == fspcp_pkg::CH_START) begin
                    pmode = PM_BODY;
                end
            end
            PM_BODY: begin
                if (b.byte_valid) begin
                    if (b.rx_byte == fspcp_pkg::CH_END) begin
                        run_command(b.live_rate);
                        pmode = PM_RESET;
                    end else if (cmd_len < FRAME_DEPTH) begin
                        cmd_buf[cmd_len] = b.rx_byte;
                        cmd_len++;
                    end else begin
                        pmode = PM_RESET;   // store full, frame dropped
                    end
                end
            end
            default: begin
                cmd_len = 0;
                pmode = PM_IDLE;
            end
        endcase
    endfunction

    // ---------------- random helpers ----------------

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(1, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [19:0] pick_rate();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 20'd0;
        end else if (r < 20) begin
            return 20'd999999;
        end else if (r < 35) begin
            return 20'($urandom_range(1000000, 1048575));
        end
        return 20'($urandom_range(0, 999999));
    endfunction

    function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
        logic [7:0] r;
        do begin
            r = 8'($urandom);
        end while (r == a || r == b || r == c);
        return r;
    endfunction

    function automatic logic [7:0] value_char();
        if ($urandom_range(0, 99) < 85) begin
            return fspcp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        end
        return byte_except(fspcp_pkg::CH_END, fspcp_pkg::CH_END, fspcp_pkg::CH_END);
    endfunction

    // ---------------- drivers ----------------

    task automatic send_poll(input logic valid_bit, input logic [7:0] ch,
                             input logic [19:0] rate);
        fspcp_pkg::t_in_beat b;
        int                  gap;
        b.byte_valid = valid_bit;
        b.rx_byte    = ch;
        b.live_rate  = rate;
        gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : idle_len();
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
        model_poll(b);
        n_polls++;
    endtask

    task automatic send_body(input logic close, input logic [19:0] close_rate);
        logic [7:0] lead;
        send_poll(1'b1, fspcp_pkg::CH_START, pick_rate());
        foreach (frame_body[i]) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
                send_poll(1'b0, 8'($urandom), pick_rate());
            end
            send_poll(1'b1, frame_body[i], pick_rate());
        end
        if (close) begin
            send_poll(1'b1, fspcp_pkg::CH_END, close_rate);
        end
        // resetting poll: whatever byte it carries is dropped
        lead = ($urandom_range(0, 2) == 0) ? fspcp_pkg::CH_START : 8'($urandom);
        send_poll(1'($urandom_range(0, 1)), lead, pick_rate());
        n_frames++;
    endtask

    task automatic run_kind(input t_frame_kind k);
        int         len;
        logic       close;
        logic [7:0] id;
        frame_body.delete();
        close = 1'b1;
        case (k)
            FK_GET: begin
                frame_body.push_back(fspcp_pkg::CH_GET);
                frame_body.push_back(fspcp_pkg::CH_A + 8'($urandom_range(0, NUM_PARAMS)));
            end
            FK_SET: begin
                len = $urandom_range(0, 9);
                frame_body.push_back(fspcp_pkg::CH_SET);
                frame_body.push_back(fspcp_pkg::CH_A + 8'($urandom_range(0, NUM_PARAMS - 1)));
                repeat (6) begin
                    frame_body.push_back(len == 0 ? fspcp_pkg::CH_NINE
                                       : len == 1 ? fspcp_pkg::CH_ZERO : value_char());
                end
            end
            FK_GET_BAD_ID: begin
                do begin
                    id = 8'($urandom);
                end while ((id >= fspcp_pkg::CH_A && id <= RUNTIME_ID)
                           || id == fspcp_pkg::CH_END);
                frame_body.push_back(fspcp_pkg::CH_GET);
                frame_body.push_back(id);
            end
            FK_SET_BAD_ID: begin
                do begin
                    id = ($urandom_range(0, 3) == 0) ? RUNTIME_ID : 8'($urandom);
                end while ((id >= fspcp_pkg::CH_A && id < RUNTIME_ID)
                           || id == fspcp_pkg::CH_END);
                frame_body.push_back(fspcp_pkg::CH_SET);
                frame_body.push_back(id);
                repeat (6) frame_body.push_back(value_char());
            end
            FK_BAD_LEN: begin
                do begin
                    len = $urandom_range(1, FRAME_DEPTH);
                end while (len == 2 || len == 8);
                frame_body.push_back($urandom_range(0, 1) ? fspcp_pkg::CH_GET
                                                          : fspcp_pkg::CH_SET);
                frame_body.push_back(fspcp_pkg::CH_A + 8'($urandom_range(0, NUM_PARAMS - 1)));
                while (frame_body.size() > len) void'(frame_body.pop_back());
                while (frame_body.size() < len) frame_body.push_back(value_char());
            end
            FK_UNKNOWN: begin
                len = $urandom_range(1, FRAME_DEPTH);
                frame_body.push_back(byte_except(fspcp_pkg::CH_GET, fspcp_pkg::CH_SET,
                                                 fspcp_pkg::CH_END));
                while (frame_body.size() < len) frame_body.push_back(value_char());
            end
            FK_OVERFLOW: begin
                close = 1'b0;
                frame_body.push_back($urandom_range(0, 1) ? fspcp_pkg::CH_GET
                                                          : fspcp_pkg::CH_SET);
                while (frame_body.size() < FRAME_DEPTH + 1) begin
                    frame_body.push_back(byte_except(fspcp_pkg::CH_END, fspcp_pkg::CH_END,
                                                     fspcp_pkg::CH_END));
                end
            end
            default: begin
            end
        endcase
        if (k == FK_NOISE) begin
            // line noise before any start character, '#' included
            repeat ($urandom_range(1, 4)) begin
                send_poll(1'($urandom_range(0, 1)),
                          byte_except(fspcp_pkg::CH_START, fspcp_pkg::CH_START,
                                      fspcp_pkg::CH_START),
                          pick_rate());
            end
        end else begin
            send_body(close, pick_rate());
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge clk);
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_commands();
        send_poll(1'b1, fspcp_pkg::CH_START, 20'd0);   // lost on the resetting poll
        frame_body = '{fspcp_pkg::CH_GET, fspcp_pkg::CH_A};
        send_body(1'b1, 20'd12345);
        frame_body = '{fspcp_pkg::CH_SET, RUNTIME_ID - 8'd1};
        repeat (6) frame_body.push_back(fspcp_pkg::CH_NINE);
        send_body(1'b1, 20'd0);
        frame_body = '{fspcp_pkg::CH_GET, RUNTIME_ID};
        send_body(1'b1, 20'hFFFFF);
        frame_body = '{fspcp_pkg::CH_GET, RUNTIME_ID - 8'd1};
        send_body(1'b1, 20'd7);
    endtask

    task automatic test_each_frame_kind();
        for (int i = FK_GET; i <= FK_NOISE; i++) begin
            run_kind(t_frame_kind'(i));
        end
    endtask

    task automatic test_drain_pause();
        run_kind(FK_SET);
        run_kind(FK_GET);
        wait_drained();
    endtask

    task automatic test_no_idle();
        quiet = 1'b1;
        repeat (6) run_kind($urandom_range(0, 1) ? FK_GET : FK_SET);
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        int r;
        while (n_polls < TARGET_POLLS) begin
            r = $urandom_range(0, 99);
            if (r < 32) begin
                run_kind(FK_GET);
            end else if (r < 64) begin
                run_kind(FK_SET);
            end else if (r < 70) begin
                run_kind(FK_GET_BAD_ID);
            end else if (r < 76) begin
                run_kind(FK_SET_BAD_ID);
            end else if (r < 82) begin
                run_kind(FK_BAD_LEN);
            end else if (r < 86) begin
                run_kind(FK_UNKNOWN);
            end else if (r < 89) begin
                run_kind(FK_EMPTY);
            end else if (r < 93) begin
                run_kind(FK_OVERFLOW);
            end else begin
                run_kind(FK_NOISE);
            end
            if ($urandom_range(0, 99) < 4) begin
                wait_drained();
            end
        end
    endtask

    // ---------------- output side ----------------

    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            out_ready  <= 1'b0;
            stall_left <= idle_len() - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : check_reply
        fspcp_pkg::t_out_beat want;
        if (rst_n && out_valid && out_ready) begin
            if (reply_q.size() == 0) begin
                $error("unexpected reply beat: tx_byte %h last %b", out_beat.tx_byte,
                       out_beat.last);
                n_errors++;
            end else begin
                want = reply_q.pop_front();
                if (out_beat.tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected %h, got %h", want.tx_byte, out_beat.tx_byte);
                    n_errors++;
                end
                if (out_beat.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, out_beat.last);
                    n_errors++;
                end
                n_beats++;
            end
        end
    end

    // no beat on either side for too long means the block is stuck
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_commands();
        test_each_frame_kind();
        test_drain_pause();
        test_no_idle();
        test_random_traffic();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d polls over %0d frames, %0d reply beats checked", n_polls, n_frames,
                 n_beats);
        $display("Mix: get/set incl. runtime id, bad ids and lengths, overflow, noise, stalls");
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
